// ----- design/tdpt_pkg.sv -----
// shared types for the trial division prime test
`timescale 1ns / 1ps

package tdpt_pkg;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CHECK  = 4'b0010,
    S_DIV    = 4'b0100,
    S_RESULT = 4'b1000
  } state_e;

  typedef struct packed {
    logic start;
  } rem_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_rsp_t;

endpackage

// ----- design/tdpt_rem_unit.sv -----
// iterative restoring remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps

module tdpt_rem_unit #(
  parameter int WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tdpt_pkg::rem_req_t req_i,
  input  logic [WIDTH-1:0]   dividend_i,
  input  logic [WIDTH-1:0]   divisor_i,
  output tdpt_pkg::rem_rsp_t rsp_o
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] rem_q, dvd_q, dsr_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q, zero_q;
  logic [WIDTH:0]   trial;
  logic [WIDTH-1:0] diff;
  logic [WIDTH-1:0] rem_d;

  assign trial = {rem_q, dvd_q[WIDTH-1]};
  assign diff  = trial[WIDTH-1:0] - dsr_q;
  assign rem_d = (trial >= {1'b0, dsr_q}) ? diff : trial[WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      dvd_q  <= {dvd_q[WIDTH-2:0], 1'b0};
      zero_q <= (rem_d == '0);
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.zero = zero_q;

endmodule

// ----- design/trial_division_prime_test_top.sv -----
// top level: trial division prime test sequencer around a shared remainder unit
//
// channel  dir  fields (tdata, lsb first)
// s_axis   in   value (WIDTH bits, signed), zero fill to whole bytes
// m_axis   out  is_prime (1 bit), zero fill to 8 bits
//
// values below 2 go straight to the result; otherwise each trial divisor takes
// one bound check plus a pass of the bit-serial remainder unit,
// for up to about sqrt(value) divisors
// s_axis_tready is high only while the sequencer is idle
// a finished word waits in the output register; a stalled sink holds the next result
// reset clears the sequencer and output valid
`timescale 1ns / 1ps

module trial_division_prime_test_top #(
  parameter int WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [((WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // value
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata   // is_prime
);

  tdpt_pkg::state_e   state_q, state_d;
  tdpt_pkg::rem_req_t rem_req;
  tdpt_pkg::rem_rsp_t rem_rsp;

  logic [WIDTH-1:0] n_q, n_d;
  logic [WIDTH-1:0] d_q, d_d;
  logic [WIDTH:0]   sq_q, sq_d;
  logic             res_q, res_d;
  logic             ovalid_q, ovalid_d;
  logic             oprime_q, oprime_d;
  logic [WIDTH-1:0] value;
  logic             in_fire;

  assign value         = s_axis_tdata[WIDTH-1:0];
  assign s_axis_tready = (state_q == tdpt_pkg::S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  tdpt_rem_unit #(
    .WIDTH(WIDTH)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (rem_req),
    .dividend_i(n_q),
    .divisor_i (d_q),
    .rsp_o     (rem_rsp)
  );

  always_comb begin
    state_d       = state_q;
    n_d           = n_q;
    d_d           = d_q;
    sq_d          = sq_q;
    res_d         = res_q;
    ovalid_d      = ovalid_q;
    oprime_d      = oprime_q;
    rem_req.start = 1'b0;
    if (m_axis_tvalid && m_axis_tready) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      tdpt_pkg::S_IDLE: begin
        if (in_fire) begin
          n_d  = value;
          d_d  = WIDTH'(2);
          sq_d = (WIDTH+1)'(4);
          if (value[WIDTH-1] || (value[WIDTH-1:1] == '0)) begin
            res_d   = 1'b0;
            state_d = tdpt_pkg::S_RESULT;
          end else begin
            state_d = tdpt_pkg::S_CHECK;
          end
        end
      end
      tdpt_pkg::S_CHECK: begin
        if (sq_q > {1'b0, n_q}) begin
          res_d   = 1'b1;
          state_d = tdpt_pkg::S_RESULT;
        end else begin
          rem_req.start = 1'b1;
          state_d       = tdpt_pkg::S_DIV;
        end
      end
      tdpt_pkg::S_DIV: begin
        if (rem_rsp.done) begin
          if (rem_rsp.zero) begin
            res_d   = 1'b0;
            state_d = tdpt_pkg::S_RESULT;
          end else begin
            d_d     = d_q + WIDTH'(1);
            sq_d    = sq_q + {d_q, 1'b1};
            state_d = tdpt_pkg::S_CHECK;
          end
        end
      end
      tdpt_pkg::S_RESULT: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          oprime_d = res_q;
          state_d  = tdpt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tdpt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tdpt_pkg::S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    d_q      <= d_d;
    sq_q     <= sq_d;
    res_q    <= res_d;
    oprime_q <= oprime_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {7'b0, oprime_q};

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("input accepted while an item is in progress");

  a_start_in_check : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_req.start |-> (state_q == tdpt_pkg::S_CHECK))
    else $error("remainder unit started outside bound check");

  a_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_rsp.done |-> (state_q == tdpt_pkg::S_DIV))
    else $error("remainder result arrived outside divide state");

endmodule

// ----- test/tb_top.sv -----
// testbench for trial_division_prime_test_top: directed and random values, primality predictor
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned STALL_LIMIT = 8_000_000;
  localparam int unsigned N_RANDOM    = 80;

  class prime_board;
    bit          want_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned primes;

    function bit prime_of(logic [31:0] v);
      longint unsigned n;
      longint unsigned d;
      if (v[31]) return 1'b0;
      n = longint'(v);
      if (n <= 1) return 1'b0;
      for (d = 2; d <= n / d; d++) begin
        if (n % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_value(logic [31:0] v);
      want_q.push_back(prime_of(v));
    endfunction

    task report(string what);
      $display("tb_top: mismatch: %s", what);
      errors++;
    endtask

    task check_word(logic [7:0] w);
      bit want;
      if (want_q.size() == 0) begin
        report($sformatf("unexpected word %h", w));
        return;
      end
      want = want_q.pop_front();
      checked++;
      if (want) primes++;
      if (w[0] !== want)
        report($sformatf("is_prime %b, expected %b (word %0d)", w[0], want, checked));
      if (w[7:1] !== 7'd0)
        report($sformatf("fill bits %b not zero (word %0d)", w[7:1], checked));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // value
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;       // is_prime

  prime_board  board = new();
  bit          no_idle = 1'b0;
  int unsigned stall_cycles = 0;
  int unsigned n_sent = 0;
  int unsigned n_negative = 0;

  trial_division_prime_test_top #(.WIDTH(32)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) board.note_value(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) board.check_word(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_top: watchdog, no word moved in %0d cycles", STALL_LIMIT);
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // sink side back-pressure
  initial begin
    forever begin
      @(negedge clk_i);
      m_axis_tready = rst_ni && (no_idle || ($urandom_range(0, 99) >= 30));
    end
  end

  task automatic send_value(input logic [31:0] v);
    while (!no_idle && $urandom_range(0, 99) < 30) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = v;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
    if (v[31]) n_negative++;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    int unsigned r;
    int unsigned a;
    int unsigned b;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 2000);
    if (r < 55) return $urandom_range(2000, 1 << 20);
    if (r < 70) return $urandom | 32'h8000_0000;
    if (r < 90) begin
      // large composite with a small factor, so the divisor search ends early
      a = $urandom_range(2, 64);
      b = $urandom_range(2, 32'h7fff_ffff / a);
      return a * b;
    end
    return $urandom & 32'hffff_fffe;
  endfunction

  initial begin
    logic [31:0] directed [$];
    directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'hffff_ffff, 32'h8000_0000,
                 32'hffff_fff9, 32'd9, 32'd25, 32'd49, 32'd97, 32'd121, 32'd961,
                 32'd65521, 32'd65535, 32'h4000_0000, 32'h7fff_fffe, 32'h7fff_ffff,
                 32'h5555_5555, 32'h2aaa_aaaa};
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (directed[i]) send_value(directed[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      no_idle = (i >= 30 && i < 60);
      send_value(pick_value());
    end
    no_idle = 1'b0;
    s_axis_tvalid = 1'b0;
    while (board.want_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("tb_top: %0d values sent, %0d negative, incl. 0, 1, 2, squares and 2^31-1",
             n_sent, n_negative);
    $display("tb_top: %0d words checked, %0d prime", board.checked, board.primes);
    if (board.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
